@@ design/rrrt_pkg.sv @@
// Package with the shared types and constants of the resource request/release table.
`default_nettype none

package rrrt_pkg;

   localparam int AMOUNT_WIDTH = 16;
   localparam int PID_WIDTH    = 4;
   localparam int OP_WIDTH     = 2;
   localparam int NUM_AMOUNTS  = 4;
   localparam int IDX_WIDTH    = 9;

   localparam logic [OP_WIDTH-1:0] OP_REQUEST    = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_RELEASE    = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_LOAD_NEED  = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_LOAD_AVAIL = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]     opcode;
      logic [PID_WIDTH-1:0]    process_id;
      logic [AMOUNT_WIDTH-1:0] amount_0;
      logic [AMOUNT_WIDTH-1:0] amount_1;
      logic [AMOUNT_WIDTH-1:0] amount_2;
      logic [AMOUNT_WIDTH-1:0] amount_3;
   } req_payload_type;

   typedef struct packed {
      logic                    granted;
      logic [AMOUNT_WIDTH-1:0] avail_0;
      logic [AMOUNT_WIDTH-1:0] avail_1;
      logic [AMOUNT_WIDTH-1:0] avail_2;
      logic [AMOUNT_WIDTH-1:0] avail_3;
   } rsp_payload_type;

   typedef struct packed {
      logic granted;
      logic need_write;
      logic avail_write;
   } update_ctrl_type;

endpackage

`default_nettype wire

@@ design/rrrt_stream_if.sv @@
// Valid/ready stream interface that carries one payload per transfer.
`default_nettype none

interface rrrt_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ design/rrrt_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module rrrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  write_enable,
   input  wire logic [ADDR_WIDTH-1:0] write_addr,
   input  wire logic [WIDTH-1:0]      write_data,
   input  wire logic                  read_enable,
   input  wire logic [ADDR_WIDTH-1:0] read_addr,
   output logic      [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= mem_ff[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

@@ design/rrrt_update.sv @@
// Grant check and update of one need row and the available counts (saturating on release, clamped on load).
`default_nettype none

module rrrt_update import rrrt_pkg::*; #(
   parameter int RESOURCES   = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  wire logic [OP_WIDTH-1:0]                          opcode,
   input  wire logic                                         in_range,
   input  wire logic [NUM_AMOUNTS-1:0][AMOUNT_WIDTH-1:0]     amount,
   input  wire logic [RESOURCES-1:0][COUNT_WIDTH-1:0]        need_row,
   input  wire logic [RESOURCES-1:0][COUNT_WIDTH-1:0]        avail,
   output logic      [RESOURCES-1:0][COUNT_WIDTH-1:0]        need_next,
   output logic      [RESOURCES-1:0][COUNT_WIDTH-1:0]        avail_next,
   output update_ctrl_type                                   ctrl
);

   localparam logic [COUNT_WIDTH-1:0]  TOP_COUNT = {COUNT_WIDTH{1'b1}};
   localparam logic [AMOUNT_WIDTH:0]   TOP_WIDE  = (AMOUNT_WIDTH+1)'(TOP_COUNT);

   logic [RESOURCES-1:0][COUNT_WIDTH-1:0] clamped;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0] need_sat;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0] avail_sat;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0] need_diff;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0] avail_diff;
   logic [RESOURCES-1:0][AMOUNT_WIDTH:0]  need_sum;
   logic [RESOURCES-1:0][AMOUNT_WIDTH:0]  avail_sum;
   logic [RESOURCES-1:0]                  fits;

   always_comb begin
      for (int r = 0; r < RESOURCES; r++) begin
         clamped[r]    = ((AMOUNT_WIDTH+1)'(amount[r]) > TOP_WIDE) ? TOP_COUNT
                         : amount[r][COUNT_WIDTH-1:0];
         need_sum[r]   = (AMOUNT_WIDTH+1)'(need_row[r]) + (AMOUNT_WIDTH+1)'(amount[r]);
         avail_sum[r]  = (AMOUNT_WIDTH+1)'(avail[r]) + (AMOUNT_WIDTH+1)'(amount[r]);
         need_sat[r]   = (need_sum[r] > TOP_WIDE) ? TOP_COUNT : need_sum[r][COUNT_WIDTH-1:0];
         avail_sat[r]  = (avail_sum[r] > TOP_WIDE) ? TOP_COUNT
                         : avail_sum[r][COUNT_WIDTH-1:0];
         need_diff[r]  = need_row[r] - amount[r][COUNT_WIDTH-1:0];
         avail_diff[r] = avail[r] - amount[r][COUNT_WIDTH-1:0];
         fits[r]       = (amount[r] <= AMOUNT_WIDTH'(avail[r]))
                         && (amount[r] <= AMOUNT_WIDTH'(need_row[r]));
      end
   end

   always_comb begin
      need_next  = need_row;
      avail_next = avail;
      ctrl       = '0;
      case (opcode)
         OP_REQUEST: begin
            ctrl.granted     = in_range && (&fits);
            ctrl.need_write  = ctrl.granted;
            ctrl.avail_write = ctrl.granted;
            if (ctrl.granted) begin
               need_next  = need_diff;
               avail_next = avail_diff;
            end
         end
         OP_RELEASE: begin
            ctrl.granted     = in_range;
            ctrl.need_write  = in_range;
            ctrl.avail_write = in_range;
            if (in_range) begin
               need_next  = need_sat;
               avail_next = avail_sat;
            end
         end
         OP_LOAD_NEED: begin
            ctrl.granted    = in_range;
            ctrl.need_write = in_range;
            if (in_range) begin
               need_next = clamped;
            end
         end
         OP_LOAD_AVAIL: begin
            ctrl.granted     = in_range;
            ctrl.avail_write = in_range;
            if (in_range) begin
               avail_next = clamped;
            end
         end
         default: begin
            ctrl = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/resource_request_release_table_unit.sv @@
// A request transfer registers the need-table RAM read and the request fields; the check and
// the need-row write-back take the execute state, which waits while an untaken result holds the output.
// A new item is taken only in the idle state, after the last one has left the execute state.
// A finished result waits in the output register while the next item is taken.
// Reset clears the available counts and the handshake state; the need table is
// undefined until each row is loaded.
`default_nettype none

module resource_request_release_table_unit import rrrt_pkg::*; #(
   parameter int PROCESSES   = 16,
   parameter int RESOURCES   = 4,
   parameter int COUNT_WIDTH = 16
) (
   input wire logic     clock,
   input wire logic     reset,
   rrrt_stream_if.sink   req_ch,
   rrrt_stream_if.source rsp_ch
);

   localparam int ADDR_WIDTH = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
   localparam int ROW_WIDTH  = RESOURCES * COUNT_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                                     state_ff;
   logic                                     state_in;
   logic [OP_WIDTH-1:0]                      opcode_ff;
   logic                                     in_range_ff;
   logic [ADDR_WIDTH-1:0]                    addr_ff;
   logic [NUM_AMOUNTS-1:0][AMOUNT_WIDTH-1:0] amount_ff;
   logic [NUM_AMOUNTS-1:0][AMOUNT_WIDTH-1:0] amount_in;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0]    avail_ff;
   logic                                     rsp_valid_ff;
   logic                                     rsp_valid_in;
   logic                                     granted_ff;
   logic [NUM_AMOUNTS-1:0][AMOUNT_WIDTH-1:0] rsp_avail_ff;
   logic [NUM_AMOUNTS-1:0][AMOUNT_WIDTH-1:0] rsp_avail_in;

   logic [IDX_WIDTH-1:0]                     pid_wide;
   logic                                     accept;
   logic                                     proceed;
   logic [ROW_WIDTH-1:0]                     need_rdata;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0]    need_row;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0]    need_next;
   logic [RESOURCES-1:0][COUNT_WIDTH-1:0]    avail_next;
   update_ctrl_type                          ctrl;

   assign accept   = req_ch.valid && req_ch.ready;
   assign proceed  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);
   assign pid_wide = IDX_WIDTH'(req_ch.payload.process_id);
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      amount_in[0] = req_ch.payload.amount_0;
      amount_in[1] = req_ch.payload.amount_1;
      amount_in[2] = req_ch.payload.amount_2;
      amount_in[3] = req_ch.payload.amount_3;
   end

   rrrt_ram #(
      .WIDTH (ROW_WIDTH),
      .DEPTH (PROCESSES)
   ) u_need_ram (
      .clock        (clock),
      .write_enable (proceed && ctrl.need_write),
      .write_addr   (addr_ff),
      .write_data   (ROW_WIDTH'(need_next)),
      .read_enable  (accept),
      .read_addr    (pid_wide[ADDR_WIDTH-1:0]),
      .read_data    (need_rdata)
   );

   assign need_row = need_rdata;

   rrrt_update #(
      .RESOURCES   (RESOURCES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_update (
      .opcode     (opcode_ff),
      .in_range   (in_range_ff),
      .amount     (amount_ff),
      .need_row   (need_row),
      .avail      (avail_ff),
      .need_next  (need_next),
      .avail_next (avail_next),
      .ctrl       (ctrl)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (proceed) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_avail_in = '0;
      for (int r = 0; r < RESOURCES; r++) begin
         rsp_avail_in[r] = AMOUNT_WIDTH'(avail_next[r]);
      end
   end

   assign rsp_valid_in = proceed || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         avail_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (proceed && ctrl.avail_write) begin
            avail_ff <= avail_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         opcode_ff   <= req_ch.payload.opcode;
         in_range_ff <= pid_wide < IDX_WIDTH'(PROCESSES);
         addr_ff     <= pid_wide[ADDR_WIDTH-1:0];
         amount_ff   <= amount_in;
      end
      if (proceed) begin
         granted_ff   <= ctrl.granted;
         rsp_avail_ff <= rsp_avail_in;
      end
   end

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.payload.granted = granted_ff;
   assign rsp_ch.payload.avail_0 = rsp_avail_ff[0];
   assign rsp_ch.payload.avail_1 = rsp_avail_ff[1];
   assign rsp_ch.payload.avail_2 = rsp_avail_ff[2];
   assign rsp_ch.payload.avail_3 = rsp_avail_ff[3];

   a_accept_starts_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("Accepted item did not enter the execute state.");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EXEC)
      else $error("Response appeared without an executed item.");

   a_out_of_range_refused: assert property (@(posedge clock) disable iff (reset)
      proceed && !in_range_ff |-> !ctrl.granted && !ctrl.need_write && !ctrl.avail_write)
      else $error("Out-of-range process changed state or was granted.");

   a_avail_only_on_exec: assert property (@(posedge clock) disable iff (reset)
      !proceed |=> $stable(avail_ff))
      else $error("Available counts changed outside an executed item.");

   a_exec_wait_holds_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC && !proceed |-> rsp_valid_ff)
      else $error("Execute stalled while the output register was empty.");

endmodule

`default_nettype wire
